// ===== rtl/core/avt_pkg.sv =====
package avt_pkg;

	// widths of the item fields
	localparam int REQ_W   = 3;
	localparam int ROW_W   = 2;
	localparam int COL_W   = 2;
	localparam int FIELD_W = 32;

	// matrix geometry: rows 0..2 linear part, row 3 translation
	localparam int N_ROWS  = 4;
	localparam int N_COLS  = 3;
	localparam int N_COEFF = N_ROWS * N_COLS;
	localparam int IDX_W   = $clog2(N_COEFF);

	// defaults for the top-level parameters
	localparam int WORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	typedef enum logic [REQ_W-1:0] {
		REQ_WRITE   = 3'd0,
		REQ_PT_FWD  = 3'd1,
		REQ_PT_INV  = 3'd2,
		REQ_DIR_FWD = 3'd3,
		REQ_DIR_INV = 3'd4,
		REQ_NORMAL  = 3'd5
	} req_t;

endpackage

// ===== rtl/core/avt_cmd_if.sv =====
interface avt_cmd_if import avt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   req_type;
	logic               matrix_sel;
	logic [ROW_W-1:0]   coeff_row;
	logic [COL_W-1:0]   coeff_col;
	logic [FIELD_W-1:0] coeff_value;
	logic [FIELD_W-1:0] in_x;
	logic [FIELD_W-1:0] in_y;
	logic [FIELD_W-1:0] in_z;

	modport source (
		output valid, req_type, matrix_sel, coeff_row, coeff_col, coeff_value,
		       in_x, in_y, in_z,
		input  ready
	);

	modport sink (
		input  valid, req_type, matrix_sel, coeff_row, coeff_col, coeff_value,
		       in_x, in_y, in_z,
		output ready
	);
endinterface

// ===== rtl/core/avt_res_if.sv =====
interface avt_res_if import avt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] out_x;
	logic [FIELD_W-1:0] out_y;
	logic [FIELD_W-1:0] out_z;
	logic               overflow;

	modport source (
		output valid, out_x, out_y, out_z, overflow,
		input  ready
	);

	modport sink (
		input  valid, out_x, out_y, out_z, overflow,
		output ready
	);
endinterface

// ===== rtl/core/affine_vector_transform.sv =====
// channel | dir | handshake   | payload
// --------+-----+-------------+--------------------------------------------------
// cmd     | in  | valid/ready | req_type, matrix_sel, coeff_row/col/value, in_x/y/z
// res     | out | valid/ready | out_x, out_y, out_z, overflow
//
// one transform item per cycle unless an output stall fills the stages, which are
// operand select, 9 parallel multipliers, pair adds, final add and round, clamp
// write items and unknown codes leave no result
// arst_n clears all stage valids and loads both matrices with identity
// each stage holds while the one after it is full and stalled, so bubbles
// close up and an item is still taken while a result waits at the output

module affine_vector_transform import avt_pkg::*; #(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	avt_cmd_if.sink  cmd,
	avt_res_if.source res
);

	// data word is the parameter width, capped at the 32-bit fields
	localparam int DW = (WORD_WIDTH < FIELD_W) ? WORD_WIDTH : FIELD_W;
	localparam int PW = 2 * DW;              // exact product
	localparam int TW = DW + FRAC_BITS;      // translation at product scale
	localparam int SW = ((PW > TW) ? PW : TW) + 3;  // four-term sum with guard bits

	localparam logic [DW-1:0] ONE_W = DW'(64'd1 << FRAC_BITS);
	localparam longint WMAX_L = (64'sd1 <<< (DW - 1)) - 64'sd1;
	localparam longint WMIN_L = -WMAX_L - 64'sd1;
	localparam logic signed [SW-1:0] WMAX_S = SW'(WMAX_L);
	localparam logic signed [SW-1:0] WMIN_S = SW'(WMIN_L);
	localparam logic signed [DW-1:0] WMAX_W = DW'(WMAX_L);
	localparam logic signed [DW-1:0] WMIN_W = DW'(WMIN_L);
	localparam logic signed [SW-1:0] HALF_S = SW'(64'sd1 <<< (FRAC_BITS - 1));

	// ------------------------------------------------------------------
	// coefficient storage, index row*3+col
	// ------------------------------------------------------------------
	logic [DW-1:0] fwd_q [N_COEFF];
	logic [DW-1:0] inv_q [N_COEFF];

	// ------------------------------------------------------------------
	// stage flow control
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5 = !v_s5 || res.ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign cmd.ready = rdy1;

	// ------------------------------------------------------------------
	// request decode
	// ------------------------------------------------------------------
	req_t             rq;
	logic             acc;
	logic             is_xform;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [DW-1:0]    wr_val;

	assign rq       = req_t'(cmd.req_type);
	assign acc      = cmd.valid && cmd.ready;
	assign is_xform = (rq == REQ_PT_FWD) || (rq == REQ_PT_INV) || (rq == REQ_DIR_FWD)
		|| (rq == REQ_DIR_INV) || (rq == REQ_NORMAL);
	// column 3 does not exist, such writes are dropped
	assign wr_en    = acc && (rq == REQ_WRITE) && (cmd.coeff_col != COL_W'(N_COLS));
	assign wr_idx   = IDX_W'(cmd.coeff_row) * IDX_W'(N_COLS) + IDX_W'(cmd.coeff_col);
	assign wr_val   = cmd.coeff_value[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < N_ROWS; r++) begin
				for (int c = 0; c < N_COLS; c++) begin
					fwd_q[r*N_COLS+c] <= (r == c) ? ONE_W : '0;
					inv_q[r*N_COLS+c] <= (r == c) ? ONE_W : '0;
				end
			end
		end else if (wr_en) begin
			if (cmd.matrix_sel) begin
				inv_q[wr_idx] <= wr_val;
			end else begin
				fwd_q[wr_idx] <= wr_val;
			end
		end
	end

	// ------------------------------------------------------------------
	// operand select: lane i gives output component i
	// point/direction: column i of the matrix; normal: row i of the inverse
	// ------------------------------------------------------------------
	logic                 sel_fwd, is_pt, is_nrm;
	logic [DW-1:0]        mtx  [N_COEFF];
	logic signed [DW-1:0] coef [N_COLS][N_COLS];
	logic signed [DW-1:0] tr   [N_COLS];

	always_comb begin
		sel_fwd = (rq == REQ_PT_FWD) || (rq == REQ_DIR_FWD);
		is_pt   = (rq == REQ_PT_FWD) || (rq == REQ_PT_INV);
		is_nrm  = (rq == REQ_NORMAL);
		for (int k = 0; k < N_COEFF; k++) begin
			mtx[k] = sel_fwd ? fwd_q[k] : inv_q[k];
		end
		for (int i = 0; i < N_COLS; i++) begin
			for (int j = 0; j < N_COLS; j++) begin
				coef[i][j] = is_nrm ? inv_q[i*N_COLS+j] : mtx[j*N_COLS+i];
			end
			// directions and normals carry no translation
			tr[i] = is_pt ? mtx[(N_ROWS-1)*N_COLS+i] : '0;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: operands captured at accept
	// ------------------------------------------------------------------
	logic signed [DW-1:0] vec_s1  [N_COLS];
	logic signed [DW-1:0] coef_s1 [N_COLS][N_COLS];
	logic signed [DW-1:0] tr_s1   [N_COLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= acc && is_xform;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			vec_s1[0] <= cmd.in_x[DW-1:0];
			vec_s1[1] <= cmd.in_y[DW-1:0];
			vec_s1[2] <= cmd.in_z[DW-1:0];
			coef_s1   <= coef;
			tr_s1     <= tr;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: nine exact products
	// ------------------------------------------------------------------
	logic signed [PW-1:0] prod_s2 [N_COLS][N_COLS];
	logic signed [DW-1:0] tr_s2   [N_COLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			for (int i = 0; i < N_COLS; i++) begin
				for (int j = 0; j < N_COLS; j++) begin
					prod_s2[i][j] <= PW'(vec_s1[j]) * PW'(coef_s1[i][j]);
				end
			end
			tr_s2 <= tr_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: pair sums; rounding half folded in with the translation
	// ------------------------------------------------------------------
	logic signed [SW-1:0] pa_s3 [N_COLS];
	logic signed [SW-1:0] pb_s3 [N_COLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			for (int i = 0; i < N_COLS; i++) begin
				pa_s3[i] <= SW'(prod_s2[i][0]) + SW'(prod_s2[i][1]);
				pb_s3[i] <= SW'(prod_s2[i][2]) + (SW'(tr_s2[i]) <<< FRAC_BITS) + HALF_S;
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 4: full sum, floor back to the data word scale (round half up)
	// ------------------------------------------------------------------
	logic signed [SW-1:0] sum_s4 [N_COLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			for (int i = 0; i < N_COLS; i++) begin
				sum_s4[i] <= (pa_s3[i] + pb_s3[i]) >>> FRAC_BITS;
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 5: saturate to the data word, output register
	// ------------------------------------------------------------------
	logic signed [DW-1:0] sat      [N_COLS];
	logic                 sat_ov;
	logic signed [DW-1:0] o_s5     [N_COLS];
	logic                 ov_s5;

	always_comb begin
		sat_ov = 1'b0;
		for (int i = 0; i < N_COLS; i++) begin
			if (sum_s4[i] > WMAX_S) begin
				sat[i] = WMAX_W;
				sat_ov = 1'b1;
			end else if (sum_s4[i] < WMIN_S) begin
				sat[i] = WMIN_W;
				sat_ov = 1'b1;
			end else begin
				sat[i] = sum_s4[i][DW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rdy5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			o_s5  <= sat;
			ov_s5 <= sat_ov;
		end
	end

	assign res.valid    = v_s5;
	assign res.out_x    = FIELD_W'(o_s5[0]);
	assign res.out_y    = FIELD_W'(o_s5[1]);
	assign res.out_z    = FIELD_W'(o_s5[2]);
	assign res.overflow = ov_s5;

`ifndef SYNTH
	// a forward write lands in the addressed coefficient
	a_fwd_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && !cmd.matrix_sel |=> fwd_q[$past(wr_idx)] == $past(wr_val))
		else $error("forward coefficient write lost");

	// writes and unknown codes never start a pipeline item
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !is_xform |=> !v_s1)
		else $error("non-transform item entered the pipeline");

	// a full stage 2 facing a stall keeps its item
	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !rdy3 |=> v_s2)
		else $error("stage 2 item dropped under stall");

	// overflow only with a component pinned at a rail
	a_ov_rail: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && ov_s5 |-> (o_s5[0] == WMAX_W || o_s5[0] == WMIN_W ||
			o_s5[1] == WMAX_W || o_s5[1] == WMIN_W ||
			o_s5[2] == WMAX_W || o_s5[2] == WMIN_W))
		else $error("overflow flagged without a saturated component");
`endif

endmodule
